// ----- design/bb3_pkg.sv -----
// ---------------------------------------------------------------------------
// bb3_pkg
// Shared constants, types and the divide-by-nine helper for the 3x3 box blur.
// ---------------------------------------------------------------------------
package bb3_pkg;

   localparam int MAX_WIDTH    = 1024;
   localparam int ADDR_W       = $clog2(MAX_WIDTH);
   localparam int FW_W         = 11;
   localparam int FH_W         = 16;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;
   localparam int CH_W         = 8;
   localparam int NUM_CH       = 3;
   localparam int PIX_W        = NUM_CH * CH_W;
   localparam int LINE_W       = 2 * PIX_W;
   localparam int CSUM_W       = 10;
   localparam int SUM_W        = 12;
   localparam int QDEPTH       = 16;
   localparam int QPTR_W       = $clog2(QDEPTH);
   localparam int QCNT_W       = QPTR_W + 1;
   localparam int MAX_PER_ITEM = 2;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd640;
   localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 16'd480;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_PAD   = 1'b1;

   // (s + 4) / 9 as (s * ceil(2^15 / 9)) >> 15, exact for s below 2^15
   localparam logic [SUM_W-1:0] ROUND_BIAS  = 12'd4;
   localparam logic [SUM_W-1:0] DIV9_RECIP  = 12'd3641;
   localparam int               DIV9_SHIFT  = 15;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
      logic            frame_end;
      logic            last;
   } result_type;

   typedef struct packed {
      logic a;
      logic b;
   } push_type;

   function automatic logic [CH_W-1:0] div9_round(input logic [SUM_W-1:0] biased_sum);
      logic [2*SUM_W-1:0] prod;
      prod = (2*SUM_W)'(biased_sum) * (2*SUM_W)'(DIV9_RECIP);
      return prod[DIV9_SHIFT +: CH_W];
   endfunction

endpackage

// ----- design/bb3_rsp_queue.sv -----
// ---------------------------------------------------------------------------
// bb3_rsp_queue
// Result queue with two push slots per cycle (in order a then b), one pop.
// ---------------------------------------------------------------------------
module bb3_rsp_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  bb3_pkg::push_type              push,
   input  bb3_pkg::result_type            data_a,
   input  bb3_pkg::result_type            data_b,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bb3_pkg::result_type            head,
   output logic [bb3_pkg::QCNT_W-1:0]     count
);
   import bb3_pkg::*;

   result_type        q_ff [QDEPTH];
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [QPTR_W-1:0] addr_b;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = q_ff[head_ff];
   assign count     = count_ff;

   always_comb begin
      addr_b   = tail_ff + QPTR_W'(push.a);
      tail_in  = tail_ff + QPTR_W'(push.a) + QPTR_W'(push.b);
      head_in  = head_ff + QPTR_W'(pop);
      count_in = count_ff + QCNT_W'(push.a) + QCNT_W'(push.b) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.a) begin
         q_ff[tail_ff] <= data_a;
      end
      if (push.b) begin
         q_ff[addr_b] <= data_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- design/box_blur_3x3_zero_pad_top.sv -----
// ---------------------------------------------------------------------------
// box_blur_3x3_zero_pad_top
// Path: an accepted pixel passes the stage 1 and stage 2 registers, then the
// result queue to rsp_; a pixel's second result is queued right behind its first.
// Throughput: one pixel per cycle while req_stall is low; the line store is
// read one cycle and written back the next, same-column hazards are forwarded.
// Reset: the whole line store is cleared afterwards while req_stall stays high.
// ---------------------------------------------------------------------------
module box_blur_3x3_zero_pad_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [bb3_pkg::CH_W-1:0]         req_in_blue,
   input  logic [bb3_pkg::CH_W-1:0]         req_in_green,
   input  logic [bb3_pkg::CH_W-1:0]         req_in_red,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bb3_pkg::CH_W-1:0]         rsp_out_blue,
   output logic [bb3_pkg::CH_W-1:0]         rsp_out_green,
   output logic [bb3_pkg::CH_W-1:0]         rsp_out_red,
   output logic                             rsp_frame_end,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bb3_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] col;
      logic [PIX_W-1:0]  pix;
      logic              row_ge1;
      logic              row_ge2;
      logic              col_zero;
      logic              last_col;
      logic              end_row;
   } s1_type;

   typedef struct packed {
      logic emit_a;
      logic emit_b;
      logic last_a;
      logic frame_end;
   } s2_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [FW_W-1:0]   frame_width_ff;
   logic [FH_W-1:0]   frame_height_ff;
   logic [ADDR_W-1:0] column_count_ff, column_count_in;
   logic [FH_W-1:0]   row_count_ff, row_count_in;

   logic              accept;
   logic [FW_W-1:0]   width_eff;
   logic [FW_W-1:0]   width_m1;
   logic [ADDR_W-1:0] last_idx;
   logic [FH_W-1:0]   height_eff;
   logic [ADDR_W-1:0] col;
   logic              last_col;
   logic              end_row;
   logic [PIX_W-1:0]  pix;

   // line store: {two rows above, row above} per column
   logic [LINE_W-1:0] line_mem [MAX_WIDTH];
   logic [LINE_W-1:0] rd_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [LINE_W-1:0] mem_wdata;

   logic              s1_valid_ff;
   s1_type            s1_ff, s1_in;
   logic              fwd_ff;
   logic [LINE_W-1:0] fwd_data_ff;
   logic [LINE_W-1:0] entry;
   logic [PIX_W-1:0]  top, mid;
   logic [LINE_W-1:0] wdata;

   logic [CSUM_W-1:0] cs_a_ff [NUM_CH];
   logic [CSUM_W-1:0] cs_b_ff [NUM_CH];
   logic [CSUM_W-1:0] cs_new  [NUM_CH];
   logic [CSUM_W-1:0] eff_a   [NUM_CH];
   logic [CSUM_W-1:0] eff_b   [NUM_CH];
   logic [SUM_W-1:0]  sum_a   [NUM_CH];
   logic [SUM_W-1:0]  sum_b   [NUM_CH];

   logic              s2_valid_ff;
   s2_type            s2_ff;
   logic [SUM_W-1:0]  sum_a_ff [NUM_CH];
   logic [SUM_W-1:0]  sum_b_ff [NUM_CH];

   push_type          push;
   result_type        res_a, res_b, rsp_head;
   logic [QCNT_W-1:0] q_count;
   logic [1:0]        in_flight;
   logic [QCNT_W:0]   need;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_data[FW_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_data[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- clear sequencer ----------------
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(MAX_WIDTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: ;
         default: state_in = ST_CLEAR;
      endcase
   end

   // ---------------- stage 0: position, line store read ----------------
   assign in_flight = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff};
   assign need      = (QCNT_W+1)'(q_count) + (QCNT_W+1)'({in_flight, 1'b0})
                    + (QCNT_W+1)'(MAX_PER_ITEM);
   assign req_stall = (state_ff != ST_RUN) || (need > (QCNT_W+1)'(QDEPTH));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = FW_W'(1);
      end else if (frame_width_ff > FW_W'(MAX_WIDTH)) begin
         width_eff = FW_W'(MAX_WIDTH);
      end else begin
         width_eff = frame_width_ff;
      end
      width_m1   = width_eff - FW_W'(1);
      last_idx   = width_m1[ADDR_W-1:0];
      height_eff = (frame_height_ff == '0) ? FH_W'(1) : frame_height_ff;
      col        = (FW_W'(column_count_ff) >= width_eff) ? last_idx : column_count_ff;
      last_col   = (col == last_idx);
      end_row    = (row_count_ff >= height_eff);
      if (req_type == REQ_PAD || end_row) begin
         pix = '0;
      end else begin
         pix = {req_in_red, req_in_green, req_in_blue};
      end

      s1_in.col      = col;
      s1_in.pix      = pix;
      s1_in.row_ge1  = (row_count_ff != '0);
      s1_in.row_ge2  = (row_count_ff > FH_W'(1));
      s1_in.col_zero = (col == '0);
      s1_in.last_col = last_col;
      s1_in.end_row  = end_row;

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (last_col) begin
            column_count_in = '0;
            row_count_in    = end_row ? '0 : row_count_ff + 1'b1;
         end else begin
            column_count_in = col + 1'b1;
         end
      end
   end

   assign mem_we    = (state_ff == ST_CLEAR) || s1_valid_ff;
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : s1_ff.col;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= line_mem[col];
   end

   // ---------------- stage 1: column sums, write back ----------------
   always_comb begin
      entry = fwd_ff ? fwd_data_ff : rd_ff;
      top   = s1_ff.row_ge2 ? entry[LINE_W-1:PIX_W] : '0;
      mid   = s1_ff.row_ge1 ? entry[PIX_W-1:0]      : '0;
      wdata = {entry[PIX_W-1:0], s1_ff.pix};
      for (int ch = 0; ch < NUM_CH; ch++) begin
         cs_new[ch] = CSUM_W'(top[ch*CH_W +: CH_W]) + CSUM_W'(mid[ch*CH_W +: CH_W])
                    + CSUM_W'(s1_ff.pix[ch*CH_W +: CH_W]);
         // window is cleared at the start of every row
         eff_a[ch]  = s1_ff.col_zero ? '0 : cs_a_ff[ch];
         eff_b[ch]  = s1_ff.col_zero ? '0 : cs_b_ff[ch];
         sum_a[ch]  = SUM_W'(eff_a[ch]) + SUM_W'(eff_b[ch]) + SUM_W'(cs_new[ch]) + ROUND_BIAS;
         // right edge: zero column shifted in
         sum_b[ch]  = SUM_W'(eff_b[ch]) + SUM_W'(cs_new[ch]) + ROUND_BIAS;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= s1_in;
         fwd_ff      <= s1_valid_ff && (col == s1_ff.col);
         fwd_data_ff <= wdata;
      end
      if (s1_valid_ff) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            cs_a_ff[ch]  <= eff_b[ch];
            cs_b_ff[ch]  <= cs_new[ch];
            sum_a_ff[ch] <= sum_a[ch];
            sum_b_ff[ch] <= sum_b[ch];
         end
      end
   end

   // ---------------- stage 2: divide by nine into the queue ----------------
   always_comb begin
      push.a          = s2_ff.emit_a;
      push.b          = s2_ff.emit_b;
      res_a.blue      = div9_round(sum_a_ff[0]);
      res_a.green     = div9_round(sum_a_ff[1]);
      res_a.red       = div9_round(sum_a_ff[2]);
      res_a.frame_end = 1'b0;
      res_a.last      = s2_ff.last_a;
      res_b.blue      = div9_round(sum_b_ff[0]);
      res_b.green     = div9_round(sum_b_ff[1]);
      res_b.red       = div9_round(sum_b_ff[2]);
      res_b.frame_end = s2_ff.frame_end;
      res_b.last      = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_addr_ff     <= '0;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s2_ff           <= '0;
      end else begin
         state_ff        <= state_in;
         clr_addr_ff     <= clr_addr_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         s1_valid_ff     <= accept;
         s2_valid_ff     <= s1_valid_ff;
         s2_ff.emit_a    <= s1_valid_ff && s1_ff.row_ge1 && !s1_ff.col_zero;
         s2_ff.emit_b    <= s1_valid_ff && s1_ff.row_ge1 && s1_ff.last_col;
         s2_ff.last_a    <= !s1_ff.last_col;
         s2_ff.frame_end <= s1_ff.end_row;
      end
   end

   bb3_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .data_a    (res_a),
      .data_b    (res_b),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (rsp_head),
      .count     (q_count)
   );

   assign rsp_out_blue  = rsp_head.blue;
   assign rsp_out_green = rsp_head.green;
   assign rsp_out_red   = rsp_head.red;
   assign rsp_frame_end = rsp_head.frame_end;
   assign rsp_last      = rsp_head.last;

endmodule

// ----- design/bb3_checker.sv -----
// ---------------------------------------------------------------------------
// bb3_checker
// Port-level checks for the box blur, bound to the top level.
// ---------------------------------------------------------------------------
module bb3_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [bb3_pkg::CH_W-1:0]       rsp_out_blue,
   input logic [bb3_pkg::CH_W-1:0]       rsp_out_green,
   input logic [bb3_pkg::CH_W-1:0]       rsp_out_red,
   input logic                           rsp_frame_end,
   input logic                           rsp_last
);

   // line store clear holds off input right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input not held off after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // frame end only on the row's closing result
   a_fend_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_last)
      else $error("frame_end without last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result beat dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_blue) && $stable(rsp_out_green)
         && $stable(rsp_out_red) && $stable(rsp_frame_end) && $stable(rsp_last))
      else $error("stalled result beat changed");

endmodule

bind box_blur_3x3_zero_pad_top bb3_checker u_bb3_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_blue  (rsp_out_blue),
   .rsp_out_green (rsp_out_green),
   .rsp_out_red   (rsp_out_red),
   .rsp_frame_end (rsp_frame_end),
   .rsp_last      (rsp_last)
);
